// ----- design/jst_pkg.sv -----
// Shared types, codes and constants of the job sleep timer table.
package jst_pkg;

   // Table size default
   localparam int MAX_SLOTS_DEFAULT = 16;

   // Field widths
   localparam int CMD_W    = 3;
   localparam int ID_W     = 16;
   localparam int TIME_W   = 16;
   localparam int ACTIVE_W = 5;
   localparam int SLOT_OUT_W = 4;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Register reset values
   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;
   localparam logic [TIME_W-1:0]   LIMIT_RESET  = 16'd500;

   // Sleep value that never wakes
   localparam logic [TIME_W-1:0] NO_WAKE = 16'hFFFF;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SET    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_TICK   = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;

   // Result kinds
   localparam logic KIND_WAKE = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_SLOTS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_TICK    = 2'd1;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT
   } state_type;

   // One table entry
   typedef struct packed {
      logic              used;
      logic [ID_W-1:0]   job;
      logic [TIME_W-1:0] sleep;
   } slot_entry_type;

   // Shared compare and subtract result
   typedef struct packed {
      logic [TIME_W-1:0] diff;
      logic              gt;
      logic              eq;
   } cmp_result_type;

endpackage

// ----- design/jst_if.sv -----
// Handshake channel interfaces for requests, results and register writes.
interface jst_req_if import jst_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [ID_W-1:0]   job_id;
   logic [TIME_W-1:0] sleep_value;
   logic [TIME_W-1:0] elapsed;

   modport source (output valid, command, job_id, sleep_value, elapsed, input ready);
   modport sink   (input valid, command, job_id, sleep_value, elapsed, output ready);
endinterface

interface jst_rsp_if import jst_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  kind;
   logic [ID_W-1:0]       woken_id;
   logic [SLOT_OUT_W-1:0] slot_index;
   logic [STATUS_W-1:0]   status;
   logic                  overlong;
   logic                  last;

   modport source (output valid, kind, woken_id, slot_index, status, overlong, last,
                   input ready);
   modport sink   (input valid, kind, woken_id, slot_index, status, overlong, last,
                   output ready);
endinterface

interface jst_csr_if import jst_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/jst_cmp_unit.sv -----
// Shared compare and subtract unit used by the scan steps of the sequencer.
module jst_cmp_unit import jst_pkg::*; (
   input  logic [TIME_W-1:0] a,
   input  logic [TIME_W-1:0] b,
   output cmp_result_type    result
);

   // Compute difference, greater-than and equality of the two operands
   always_comb begin
      result.diff = a - b;
      result.gt   = (a > b);
      result.eq   = (a == b);
   end

endmodule

// ----- design/jst_slot_table.sv -----
// Slot register file: one read port and one write port, used bits cleared at reset.
module jst_slot_table import jst_pkg::*; #(
   parameter int DEPTH  = MAX_SLOTS_DEFAULT,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [ADDR_W-1:0] rd_addr,
   output slot_entry_type    rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  slot_entry_type    wr_data
);

   logic [DEPTH-1:0]  used_ff;
   logic [ID_W-1:0]   job_ff   [DEPTH];
   logic [TIME_W-1:0] sleep_ff [DEPTH];

   // Clear used bits at reset, update on write
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (wr_en) begin
         used_ff[wr_addr] <= wr_data.used;
      end
   end

   // Hold job id and counter, update on write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         job_ff[wr_addr]   <= wr_data.job;
         sleep_ff[wr_addr] <= wr_data.sleep;
      end
   end

   // Read the addressed entry
   assign rd_data.used  = used_ff[rd_addr];
   assign rd_data.job   = job_ff[rd_addr];
   assign rd_data.sleep = sleep_ff[rd_addr];

endmodule

// ----- design/job_sleep_timer_table.sv -----
// Job sleep timer table: slot walk sequencer over a shared compare unit.
// Flow: an item is taken in the idle state, then walks one slot per cycle while
//   rsp ready does not hold it; its last result is registered when the walk
//   ends (active slots are capped at MAX_SLOTS).
// A new item is taken only after the last result of the previous one is emitted.
// Add, lookup and set end the walk early at a hit; the walk goes slot by slot over the table.
// Reset: synchronous, clears all used bits, result valid and sequencer; registers
//   return to 16 active slots and a long tick limit of 500.
module job_sleep_timer_table import jst_pkg::*; #(
   parameter int MAX_SLOTS = MAX_SLOTS_DEFAULT
) (
   input logic    clock,
   input logic    reset,
   jst_req_if.sink   req_if,
   jst_rsp_if.source rsp_if,
   jst_csr_if.sink   csr_if
);

   localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
   localparam int CMP_W  = (CNT_W > ACTIVE_W) ? CNT_W + 1 : ACTIVE_W + 1;

   // Mask a slot position to the result field
   function automatic logic [SLOT_OUT_W-1:0] slot_field(input logic [31:0] pos);
      return pos[SLOT_OUT_W-1:0];
   endfunction

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    ptr_ff, ptr_in;
   logic [CNT_W-1:0]    found_ff, found_in;
   logic [CNT_W-1:0]    n_ff, n_in;
   logic [CMD_W-1:0]    cmd_ff;
   logic [ID_W-1:0]     id_ff;
   logic [TIME_W-1:0]   sv_ff;
   logic [TIME_W-1:0]   el_ff;
   logic [ACTIVE_W-1:0] active_ff;
   logic [TIME_W-1:0]   limit_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_kind_ff;
   logic [ID_W-1:0]       rsp_id_ff;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic                  rsp_over_ff;
   logic                  rsp_last_ff;

   logic                  emit;
   logic                  e_kind;
   logic [ID_W-1:0]       e_id;
   logic [SLOT_OUT_W-1:0] e_slot;
   logic [STATUS_W-1:0]   e_status;
   logic                  e_over;
   logic                  e_last;

   logic              can_emit;
   logic              at_end;
   logic [CNT_W-1:0]  ptr_plus;
   logic [CMP_W-1:0]  act_ext;
   logic [SLOT_W-1:0] rd_addr;
   slot_entry_type    rd_data;
   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   slot_entry_type    wr_data;
   logic [TIME_W-1:0] cmp_a, cmp_b;
   cmp_result_type    cmp;

   // Slot storage
   jst_slot_table #(
      .DEPTH  (MAX_SLOTS),
      .ADDR_W (SLOT_W)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // Shared compare unit
   jst_cmp_unit u_cmp (
      .a      (cmp_a),
      .b      (cmp_b),
      .result (cmp)
   );

   // Take register writes at any time
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
         limit_ff  <= LIMIT_RESET;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            CSR_ACTIVE_SLOTS: active_ff <= csr_if.data[ACTIVE_W-1:0];
            CSR_LONG_TICK:    limit_ff  <= csr_if.data[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   // Cap the active slot count at the table depth
   assign act_ext = CMP_W'(active_ff);
   assign n_in    = (act_ext > CMP_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : CNT_W'(active_ff);

   // Walk helpers
   assign can_emit = !rsp_valid_ff || rsp_if.ready;
   assign at_end   = (ptr_ff == n_ff);
   assign ptr_plus = ptr_ff + CNT_W'(1);
   assign rd_addr  = (state_ff == ST_SHIFT) ? ptr_plus[SLOT_W-1:0] : ptr_ff[SLOT_W-1:0];

   // Steer the shared unit operands
   always_comb begin
      if (cmd_ff == CMD_TICK) begin
         cmp_a = at_end ? el_ff : rd_data.sleep;
         cmp_b = at_end ? limit_ff : el_ff;
      end else begin
         cmp_a = rd_data.job;
         cmp_b = id_ff;
      end
   end

   // Sequencer: next state, table writes and result words
   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      found_in     = found_ff;
      req_if.ready = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = ptr_ff[SLOT_W-1:0];
      wr_data      = rd_data;
      emit         = 1'b0;
      e_kind       = KIND_DONE;
      e_id         = id_ff;
      e_slot       = '0;
      e_status     = STAT_OK;
      e_over       = 1'b0;
      e_last       = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               state_in = ST_SCAN;
               ptr_in   = '0;
            end
         end

         ST_SCAN: begin
            if (!(cmd_ff inside {[CMD_ADD:CMD_TICK]})) begin
               // Unknown command: complete with no change
               emit = 1'b1;
               if (can_emit) state_in = ST_IDLE;
            end else if (at_end) begin
               // Walk finished with no hit, or tick done
               emit = 1'b1;
               case (cmd_ff)
                  CMD_ADD: e_status = STAT_FULL;
                  CMD_TICK: begin
                     e_id   = '0;
                     e_over = cmp.gt;
                  end
                  default: e_status = STAT_NOT_FOUND;
               endcase
               if (can_emit) state_in = ST_IDLE;
            end else begin
               case (cmd_ff)
                  CMD_ADD: begin
                     if (!rd_data.used) begin
                        emit   = 1'b1;
                        e_slot = slot_field(32'(ptr_ff));
                        if (can_emit) begin
                           wr_en         = 1'b1;
                           wr_data.used  = 1'b1;
                           wr_data.job   = id_ff;
                           wr_data.sleep = sv_ff;
                           state_in      = ST_IDLE;
                        end
                     end else begin
                        ptr_in = ptr_plus;
                     end
                  end
                  CMD_REMOVE: begin
                     if (rd_data.used && cmp.eq) begin
                        found_in = ptr_ff;
                        state_in = ST_SHIFT;
                     end else begin
                        ptr_in = ptr_plus;
                     end
                  end
                  CMD_LOOKUP, CMD_SET: begin
                     if (rd_data.used && cmp.eq) begin
                        emit   = 1'b1;
                        e_slot = slot_field(32'(ptr_ff));
                        if (can_emit) begin
                           if (cmd_ff == CMD_SET) begin
                              wr_en         = 1'b1;
                              wr_data.sleep = sv_ff;
                           end
                           state_in = ST_IDLE;
                        end
                     end else begin
                        ptr_in = ptr_plus;
                     end
                  end
                  default: begin
                     // Tick: count down or wake the job in this slot
                     if (rd_data.used && rd_data.sleep != NO_WAKE) begin
                        if (cmp.gt) begin
                           wr_en         = 1'b1;
                           wr_data.sleep = cmp.diff;
                           ptr_in        = ptr_plus;
                        end else begin
                           emit   = 1'b1;
                           e_kind = KIND_WAKE;
                           e_id   = rd_data.job;
                           e_slot = slot_field(32'(ptr_ff));
                           e_last = 1'b0;
                           if (can_emit) begin
                              wr_en         = 1'b1;
                              wr_data.sleep = '0;
                              ptr_in        = ptr_plus;
                           end
                        end
                     end else begin
                        ptr_in = ptr_plus;
                     end
                  end
               endcase
            end
         end

         ST_SHIFT: begin
            if (ptr_plus < n_ff) begin
               // Move the next entry forward
               wr_en  = 1'b1;
               ptr_in = ptr_plus;
            end else begin
               // Clear the last active slot and complete
               emit   = 1'b1;
               e_slot = slot_field(32'(found_ff));
               if (can_emit) begin
                  wr_en         = 1'b1;
                  wr_data.used  = 1'b0;
                  wr_data.job   = '0;
                  wr_data.sleep = '0;
                  state_in      = ST_IDLE;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ptr_ff   <= '0;
         found_ff <= '0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         found_ff <= found_in;
      end
   end

   // Capture the accepted word
   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         cmd_ff <= req_if.command;
         id_ff  <= req_if.job_id;
         sv_ff  <= req_if.sleep_value;
         el_ff  <= req_if.elapsed;
         n_ff   <= n_in;
      end
   end

   // Result register: load on emit, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit && can_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit && can_emit) begin
         rsp_kind_ff   <= e_kind;
         rsp_id_ff     <= e_id;
         rsp_slot_ff   <= e_slot;
         rsp_status_ff <= e_status;
         rsp_over_ff   <= e_over;
         rsp_last_ff   <= e_last;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.kind       = rsp_kind_ff;
   assign rsp_if.woken_id   = rsp_id_ff;
   assign rsp_if.slot_index = rsp_slot_ff;
   assign rsp_if.status     = rsp_status_ff;
   assign rsp_if.overlong   = rsp_over_ff;
   assign rsp_if.last       = rsp_last_ff;

endmodule

// ----- design/jst_checker.sv -----
// Port-level assertions for the job sleep timer table, bound to the top level.
module jst_checker import jst_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_kind,
   input logic [ID_W-1:0]       rsp_woken_id,
   input logic [STATUS_W-1:0]   rsp_status,
   input logic                  rsp_overlong,
   input logic                  rsp_last
);

   // A stalled result word stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // An accepted command leaves ready low in the cycle after acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after accepting a word");

   // A pending wakeup means the tick is still running; the word is not final, OK and not overlong
   a_wake_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_WAKE |-> !req_ready && !rsp_last
         && rsp_status == STAT_OK && !rsp_overlong)
      else $error("wakeup word malformed or block idle during tick");

   // Only a tick completion flags overlong, and it is always final
   a_overlong_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overlong |-> rsp_kind == KIND_DONE && rsp_last
         && rsp_woken_id == '0)
      else $error("overlong flag on a word other than tick completion");

endmodule

bind job_sleep_timer_table jst_checker u_jst_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_kind     (rsp_if.kind),
   .rsp_woken_id (rsp_if.woken_id),
   .rsp_status   (rsp_if.status),
   .rsp_overlong (rsp_if.overlong),
   .rsp_last     (rsp_if.last)
);
